// File: rtl/core/grb_pkg.sv
// Shared types and constants for the group reverse buffer.
package grb_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned GSIZE_W   = 5;
    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } grb_state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic adv;
    } grb_cmd_t;

    typedef struct packed {
        logic emit;
        logic done;
    } grb_status_t;

endpackage

// File: rtl/core/grb_if.sv
// Request channels of the group reverse buffer: input, output and configuration.
interface grb_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [grb_pkg::VALUE_W-1:0]  value_in;
    logic                                seq_end;

    modport source (output valid, output value_in, output seq_end, input ready);
    modport sink   (input valid, input value_in, input seq_end, output ready);
endinterface

interface grb_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [grb_pkg::VALUE_W-1:0]  value_out;
    logic                                out_last;

    modport source (output valid, output value_out, output out_last, input ready);
    modport sink   (input valid, input value_out, input out_last, output ready);
endinterface

interface grb_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [grb_pkg::GSIZE_W-1:0]         group_size;

    modport source (output valid, output group_size, input ready);
    modport sink   (input valid, input group_size, output ready);
endinterface

// File: rtl/core/group_reverse_buffer_core.sv
// Top level of the group reverse buffer.
// Values held until group_size of them (capped at MAX_GROUP) are present, then emitted newest
// first; at seq_end a partial group leaves in arrival order with out_last on its final value,
// and group_size 0 flushes any held values then passes the new one. An input that closes a
// group of n values, or a sequence, blocks the input side while the group drains: each result
// passes through a registered read of the group store and is then presented, and any output
// stall holds the drain.
// Configuration writes are always taken and should arrive only while idle.
module group_reverse_buffer_core
#(
    parameter int unsigned MAX_GROUP = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    grb_in_if.sink    src,
    grb_out_if.source dst,
    grb_cfg_if.sink   cfg
);

    grb_pkg::grb_cmd_t    cmd;
    grb_pkg::grb_status_t status;

    assign cfg.ready = 1'b1;

    grb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src.valid),
        .in_ready  (src.ready),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .status    (status),
        .cmd       (cmd)
    );

    grb_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.group_size),
        .value_in  (src.value_in),
        .seq_end   (src.seq_end),
        .cmd       (cmd),
        .status    (status),
        .value_out (dst.value_out),
        .out_last  (dst.out_last)
    );

`ifndef SYNTH
    a_no_input_while_showing: assert property (
        @(posedge clk) disable iff (!rst_n)
        dst.valid |-> !src.ready
    ) else $error("input ready while a result is shown");

    a_accept_then_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (src.valid && src.ready) |=> !dst.valid
    ) else $error("result shown the cycle after an accepted request");

    a_last_returns_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (dst.valid && dst.ready && dst.out_last) |=> src.ready
    ) else $error("input not ready after the final result of a sequence");
`endif

endmodule

// File: rtl/core/grb_ctrl.sv
// Sequencing state machine of the group reverse buffer.
module grb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  grb_pkg::grb_status_t status,
    output grb_pkg::grb_cmd_t    cmd
);

    grb_pkg::grb_state_t state_reg;
    grb_pkg::grb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            grb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.emit)
                    begin
                        state_next = grb_pkg::ST_READ;
                    end
                end
            end
            grb_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = grb_pkg::ST_SHOW;
            end
            grb_pkg::ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.done)
                    begin
                        state_next = grb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = grb_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = grb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/grb_datapath.sv
// Group store, fill count, read pointer and output register of the group reverse buffer.
module grb_datapath
#(
    parameter int unsigned MAX_GROUP = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [grb_pkg::GSIZE_W-1:0]         cfg_data,
    input  logic signed [grb_pkg::VALUE_W-1:0]  value_in,
    input  logic                                seq_end,
    input  grb_pkg::grb_cmd_t                   cmd,
    output grb_pkg::grb_status_t                status,
    output logic signed [grb_pkg::VALUE_W-1:0]  value_out,
    output logic                                out_last
);

    localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int unsigned CW = $clog2(MAX_GROUP + 1);
    localparam int unsigned EW = (CW > grb_pkg::GSIZE_W) ? CW : grb_pkg::GSIZE_W;

    logic signed [grb_pkg::VALUE_W-1:0] store_reg [MAX_GROUP];

    logic [grb_pkg::GSIZE_W-1:0] gsize_reg;
    logic [AW-1:0]               fill_reg;
    logic [AW-1:0]               fill_next;
    logic [AW-1:0]               ptr_reg;
    logic [AW-1:0]               ptr_next;
    logic [AW-1:0]               rem_reg;
    logic [AW-1:0]               rem_next;
    logic                        rev_reg;
    logic                        rev_next;
    logic                        end_reg;
    logic                        end_next;
    logic signed [grb_pkg::VALUE_W-1:0] data_reg;
    logic                        last_reg;

    logic [EW-1:0] gsize_ext;
    logic [EW-1:0] eff;
    logic [EW-1:0] count_ext;
    logic          full;
    logic          fwd;

    always_comb
    begin
        gsize_ext = EW'(gsize_reg);
        eff       = (gsize_ext > EW'(MAX_GROUP)) ? EW'(MAX_GROUP) : gsize_ext;
        count_ext = EW'(fill_reg) + EW'(1);
        full      = (eff != '0) && (count_ext >= eff);
        fwd       = (eff == '0) || seq_end;
    end

    assign status.emit = full || fwd;
    assign status.done = (rem_reg == '0);

    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        rem_next  = rem_reg;
        rev_next  = rev_reg;
        end_next  = end_reg;
        if (cmd.load)
        begin
            if (full || fwd)
            begin
                ptr_next  = full ? fill_reg : '0;
                rem_next  = fill_reg;
                rev_next  = full;
                end_next  = seq_end;
                fill_next = '0;
            end
            else
            begin
                fill_next = fill_reg + AW'(1);
            end
        end
        else if (cmd.adv)
        begin
            ptr_next = rev_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
            rem_next = rem_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= grb_pkg::GSIZE_RESET;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            rem_reg   <= '0;
            rev_reg   <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gsize_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            rem_reg  <= rem_next;
            rev_reg  <= rev_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_reg[fill_reg] <= value_in;
        end
        if (cmd.rd)
        begin
            data_reg <= store_reg[ptr_reg];
            last_reg <= end_reg && (rem_reg == '0);
        end
    end

    assign value_out = data_reg;
    assign out_last  = last_reg;

endmodule

// File: test/tb_group_reverse_buffer_core.sv
// Testbench for the group reverse buffer core: randomised request streams checked against a predictor.
`timescale 1ns / 1ps

module tb_group_reverse_buffer_core;

    localparam int unsigned MAX_GROUP = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 360;

    typedef struct {
        logic signed [grb_pkg::VALUE_W-1:0] value;
        logic                               seq_end;
    } stream_item_t;

    typedef struct {
        logic signed [grb_pkg::VALUE_W-1:0] value;
        logic                               last;
    } reordered_t;

    logic clk;
    logic rst_n;

    grb_in_if  in_ch ();
    grb_out_if out_ch ();
    grb_cfg_if cfg_ch ();

    group_reverse_buffer_core #(
        .MAX_GROUP (MAX_GROUP)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (in_ch),
        .dst   (out_ch),
        .cfg   (cfg_ch)
    );

    stream_item_t                       stream_q[$];
    reordered_t                         reordered_q[$];
    logic signed [grb_pkg::VALUE_W-1:0] held_vals [MAX_GROUP];
    int unsigned                        held_count;
    logic [grb_pkg::GSIZE_W-1:0]        model_gsize;
    int unsigned                        items_queued;
    int unsigned                        items_taken;
    int unsigned                        error_count;
    int unsigned                        cycle_count;
    int unsigned                        in_gap;
    int unsigned                        out_stall;
    logic                               in_taken;
    logic                               out_taken;
    logic                               no_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [grb_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void expect_value(logic signed [grb_pkg::VALUE_W-1:0] v, logic last);
        reordered_t r;
        r.value = v;
        r.last  = last;
        reordered_q.insert(reordered_q.size(), r);
    endfunction

    task automatic compute_reordered(input logic signed [grb_pkg::VALUE_W-1:0] v, input logic e);
        int unsigned eff;
        int i;
        eff = (model_gsize > MAX_GROUP) ? MAX_GROUP : model_gsize;
        if (eff == 0)
        begin
            for (i = 0; i < held_count; i++)
                expect_value(held_vals[i], 1'b0);
            expect_value(v, e);
            held_count = 0;
        end
        else
        begin
            held_vals[held_count] = v;
            held_count++;
            if (held_count >= eff)
            begin
                for (i = held_count - 1; i >= 0; i--)
                    expect_value(held_vals[i], e && (i == 0));
                held_count = 0;
            end
            else if (e)
            begin
                for (i = 0; i < held_count; i++)
                    expect_value(held_vals[i], i + 1 == held_count);
                held_count = 0;
            end
        end
    endtask

    // Monitor: check results, then predict from accepted requests
    always @(posedge clk)
    begin
        reordered_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        in_taken  = rst_n && in_ch.valid && in_ch.ready;
        out_taken = rst_n && out_ch.valid && out_ch.ready;
        if (out_taken)
        begin
            if (reordered_q.size() == 0)
            begin
                $error("unexpected result: value_out %0d out_last %0b",
                       out_ch.value_out, out_ch.out_last);
                error_count++;
            end
            else
            begin
                want = reordered_q.pop_front();
                if (out_ch.value_out !== want.value)
                begin
                    $error("value_out mismatch: expected %0d, actual %0d",
                           want.value, out_ch.value_out);
                    error_count++;
                end
                if (out_ch.out_last !== want.last)
                begin
                    $error("out_last mismatch: expected %0b, actual %0b",
                           want.last, out_ch.out_last);
                    error_count++;
                end
            end
        end
        if (in_taken)
        begin
            compute_reordered(in_ch.value_in, in_ch.seq_end);
            items_taken++;
        end
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            model_gsize = cfg_ch.group_size;
    end

    // Request driver: hold until taken, then idle or advance
    always @(negedge clk)
    begin
        stream_item_t item;
        if (in_ch.valid && !in_taken)
        begin
        end
        else if (in_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            in_gap--;
        end
        else if (stream_q.size() > 0)
        begin
            item = stream_q.pop_front();
            in_ch.valid    <= 1'b1;
            in_ch.value_in <= item.value;
            in_ch.seq_end  <= item.seq_end;
            in_gap = no_idle ? 0 : gap_len();
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result sink: stall at random after each taken result, unless no_idle is set
    always @(negedge clk)
    begin
        if (out_taken && !no_idle)
            out_stall = gap_len();
        if (out_stall > 0)
        begin
            out_ch.ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic queue_value(input logic signed [grb_pkg::VALUE_W-1:0] v, input logic e);
        stream_item_t item;
        item.value   = v;
        item.seq_end = e;
        stream_q.insert(stream_q.size(), item);
        items_queued++;
    endtask

    task automatic drain_stream();
        while (!(items_taken == items_queued && reordered_q.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_group_size(input logic [grb_pkg::GSIZE_W-1:0] gs);
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.group_size <= gs;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned eff;
        int unsigned seqs;
        int unsigned len;
        int unsigned s;
        int unsigned k;
        logic [grb_pkg::GSIZE_W-1:0] gs;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.value_in    = '0;
        in_ch.seq_end     = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.group_size = '0;
        model_gsize       = grb_pkg::GSIZE_RESET;
        held_count        = 0;
        items_queued      = 0;
        items_taken       = 0;
        error_count       = 0;
        cycle_count       = 0;
        in_gap            = 0;
        out_stall         = 0;
        in_taken          = 1'b0;
        out_taken         = 1'b0;
        no_idle           = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // group of one at the reset size, field extremes
        queue_value(32'sh7FFF_FFFF, 1'b0);
        queue_value(32'sh8000_0000, 1'b0);
        queue_value('0, 1'b0);
        queue_value('1, 1'b1);
        drain_stream();

        // group closing on the sequence end, then a partial group
        write_group_size(5'd3);
        queue_value(11, 1'b0);
        queue_value(12, 1'b0);
        queue_value(13, 1'b1);
        queue_value(14, 1'b0);
        queue_value(15, 1'b1);
        drain_stream();

        // lower the size while values are held
        write_group_size(5'd4);
        queue_value(21, 1'b0);
        queue_value(22, 1'b0);
        queue_value(23, 1'b0);
        drain_stream();
        write_group_size(5'd2);
        queue_value(24, 1'b0);
        queue_value(25, 1'b0);
        drain_stream();

        // pass through with a held value
        write_group_size(5'd0);
        queue_value(26, 1'b0);
        queue_value(27, 1'b1);
        drain_stream();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: gs = 5'd16;
                1: gs = 5'd31;
                2: gs = 5'd0;
                3: gs = 5'd17;
                default:
                    gs = 5'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 31));
            endcase
            write_group_size(gs);
            eff = (gs > MAX_GROUP) ? MAX_GROUP : gs;
            no_idle = ($urandom_range(0, 4) == 0);
            seqs = $urandom_range(2, 6);
            for (s = 0; s < seqs; s++)
            begin
                len = (eff == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2 * eff + 1);
                for (k = 0; k < len; k++)
                    queue_value(rand_value(), k + 1 == len);
                random_items += len;
            end
            // leave a tail held for the next size
            if (eff >= 2 && $urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, eff - 1);
                for (k = 0; k < len; k++)
                    queue_value(rand_value(), 1'b0);
                random_items += len;
            end
            drain_stream();
            phase++;
        end

        write_group_size(5'd1);
        queue_value(rand_value(), 1'b1);
        drain_stream();

        if (error_count == 0 && reordered_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
